// ===== sv/ocms_pkg.sv =====
// Package for the orbit correction step: codes, widths, defaults and states.
`default_nettype none
package ocms_pkg;

  // Default sizes
  localparam int MONITORS_DEF     = 64;
  localparam int H_CORRECTORS_DEF = 24;
  localparam int V_CORRECTORS_DEF = 24;

  // Fixed field widths
  localparam int CMD_W   = 3;
  localparam int IDX_W   = 6;
  localparam int WORD_W  = 32;
  localparam int CORR_W  = 5;
  localparam int CFG_IW  = 3;
  localparam int STEP_W  = 31;
  localparam int FRAC_W  = 17;

  // Datapath widths
  localparam int DELTA_W = 33;              // exact difference of two Q16.16
  localparam int ACC_W   = 48;              // Q32.16 sum, magnitude below 2^46
  localparam int MAG_W   = 47;              // kick magnitude and step limit
  localparam int OPA_W   = 51;              // three 17-bit slices
  localparam int OPB_W   = 64;              // two 32-bit slices
  localparam int ASL_W   = 17;
  localparam int BSL_W   = 32;
  localparam int PP_W    = ASL_W + BSL_W;
  localparam int PROD_W  = 96;
  localparam int SH_W    = 7;
  localparam int MCNT_W  = 3;
  localparam int DCNT_W  = 7;
  localparam int SUM_W   = 35;

  localparam logic [MCNT_W-1:0] MUL_LAST = MCNT_W'(6);
  localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(PROD_W - 1);

  // Input commands
  localparam logic [CMD_W-1:0] CMD_H_COEF = 3'd0;
  localparam logic [CMD_W-1:0] CMD_V_COEF = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MON    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CORR   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RUN    = 3'd4;

  // Register indexes
  localparam logic [CFG_IW-1:0] CFG_MAX_H  = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_MAX_V  = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_FRAC_H = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_FRAC_V = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_LOADED = 3'd4;

  // Register reset values
  localparam logic [STEP_W-1:0] STEP_RST = STEP_W'(1000);
  localparam logic [FRAC_W-1:0] FRAC_RST = FRAC_W'(65536);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PLANE,
    S_MAC_RD,
    S_MAC_CHK,
    S_MAC_MUL,
    S_MAC_ACC,
    S_ROW_END,
    S_AP_RD,
    S_AP_CHK,
    S_AP_LMUL,
    S_AP_DIV,
    S_AP_FMUL,
    S_AP_ADD,
    S_AP_OUT
  } state_t;

endpackage
`default_nettype wire

// ===== sv/orbit_correction_matrix_step.sv =====
// Orbit correction step: matrix store, shared slice multiplier, divider and sequencer.
//
//   channel  | handshake            | word
//   ---------+----------------------+--------------------------------------------
//   in_      | in_valid / in_ready  | command, indexes, plane, coefficient, records
//   out_     | out_valid / out_ready| plane, corrector, new setpoint, last
//   cfg_     | cfg_valid / cfg_ready| register index, data
//
// Load words are taken while the sequencer idles; in_ready is high whenever it idles.
// A run sums, for each corrector of each plane, its matrix row against the deltas of
// the enabled monitors (one pass of the 17x32 slice multiplier per product), then
// applies each kick, using the 96-step restoring divider when the plane is limited.
// Reset is synchronous; no clearing pass, stores with a reset value carry valid bits.
// A stalled result word holds the sequencer until out_ready takes it.
`default_nettype none
module orbit_correction_matrix_step #(
  parameter int MONITORS     = ocms_pkg::MONITORS_DEF,
  parameter int H_CORRECTORS = ocms_pkg::H_CORRECTORS_DEF,
  parameter int V_CORRECTORS = ocms_pkg::V_CORRECTORS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic [ocms_pkg::CMD_W-1:0]  in_command,
  input  wire logic [ocms_pkg::IDX_W-1:0]  in_row_index,
  input  wire logic [ocms_pkg::IDX_W-1:0]  in_column_index,
  input  wire logic                        in_plane,
  input  wire logic signed [31:0]          in_coefficient,
  input  wire logic signed [31:0]          in_x_position,
  input  wire logic signed [31:0]          in_y_position,
  input  wire logic signed [31:0]          in_x_reference,
  input  wire logic signed [31:0]          in_y_reference,
  input  wire logic                        in_monitor_enabled,
  input  wire logic signed [31:0]          in_corrector_setpoint,
  input  wire logic                        in_corrector_enabled,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic                        out_plane,
  output      logic [ocms_pkg::CORR_W-1:0] out_corrector,
  output      logic signed [31:0]          out_new_setpoint,
  output      logic                        out_last,
  input  wire logic                        cfg_valid,
  output      logic                        cfg_ready,
  input  wire logic [ocms_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [31:0]                 cfg_data
);

  localparam int NCORR     = H_CORRECTORS + V_CORRECTORS;
  localparam int CORR_IW   = $clog2(NCORR);
  localparam int MON_IW    = (MONITORS > 1) ? $clog2(MONITORS) : 1;
  localparam int MAT_DEPTH = NCORR * MONITORS;
  localparam int MAT_AW    = $clog2(MAT_DEPTH);
  localparam int ROW_W     = ocms_pkg::CORR_W;
  localparam int DW        = ocms_pkg::DELTA_W;
  localparam int AW        = ocms_pkg::ACC_W;
  localparam int MW        = ocms_pkg::MAG_W;

  // ---------------- configuration registers ----------------
  logic [ocms_pkg::STEP_W-1:0] max_h_r, max_v_r;
  logic [ocms_pkg::FRAC_W-1:0] frac_h_r, frac_v_r;
  logic                        loaded_r;
  logic                        cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_h_r  <= ocms_pkg::STEP_RST;
      max_v_r  <= ocms_pkg::STEP_RST;
      frac_h_r <= ocms_pkg::FRAC_RST;
      frac_v_r <= ocms_pkg::FRAC_RST;
      loaded_r <= 1'b0;
    end else if (cfg_fire) begin
      case (cfg_index)
        ocms_pkg::CFG_MAX_H:  max_h_r  <= cfg_data[ocms_pkg::STEP_W-1:0];
        ocms_pkg::CFG_MAX_V:  max_v_r  <= cfg_data[ocms_pkg::STEP_W-1:0];
        ocms_pkg::CFG_FRAC_H: frac_h_r <= cfg_data[ocms_pkg::FRAC_W-1:0];
        ocms_pkg::CFG_FRAC_V: frac_v_r <= cfg_data[ocms_pkg::FRAC_W-1:0];
        ocms_pkg::CFG_LOADED: loaded_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------- state and datapath registers ----------------
  ocms_pkg::state_t state_r, state_nxt;

  logic                         plane_r, plane_nxt;
  logic [ROW_W-1:0]             row_r, row_nxt;
  logic [MON_IW-1:0]            s_r, s_nxt;
  logic [MON_IW:0]              col_r, col_nxt;
  logic [MAT_AW-1:0]            mat_base_r, mat_base_nxt;
  logic signed [AW-1:0]         acc_r, acc_nxt;
  logic [MW-1:0]                maxmag_r, maxmag_nxt;
  logic [ocms_pkg::OPA_W-1:0]   opa_r, opa_nxt;
  logic [ocms_pkg::OPB_W-1:0]   opb_r, opb_nxt;
  logic                         neg_r, neg_nxt;
  logic [ocms_pkg::MCNT_W-1:0]  mcnt_r, mcnt_nxt;
  logic [ocms_pkg::PP_W-1:0]    pp_r, pp_nxt;
  logic                         pp_v_r, pp_v_nxt;
  logic [ocms_pkg::SH_W-1:0]    sh_r, sh_nxt;
  logic [ocms_pkg::PROD_W-1:0]  prod_r, prod_nxt;
  logic [MW:0]                  rem_r, rem_nxt;
  logic [MW:0]                  quo_r, quo_nxt;
  logic [ocms_pkg::DCNT_W-1:0]  dcnt_r, dcnt_nxt;
  logic signed [31:0]           sp_r, sp_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic                         out_plane_r, out_plane_nxt;
  logic [ROW_W-1:0]             out_corr_r, out_corr_nxt;
  logic signed [31:0]           out_sp_r, out_sp_nxt;
  logic                         out_last_r, out_last_nxt;

  logic [MONITORS-1:0]          mon_en_r;
  logic [NCORR-1:0]             corr_en_r;
  logic [NCORR-1:0]             cval_r;

  // ---------------- memories ----------------
  logic [31:0]       mat_mem [MAT_DEPTH];
  logic [2*DW-1:0]   dlt_mem [MONITORS];
  logic [AW-1:0]     kick_mem [NCORR];
  logic [31:0]       sp_mem [NCORR];

  logic [31:0]       mat_q;
  logic [2*DW-1:0]   dlt_q;
  logic [AW-1:0]     kick_q;
  logic [31:0]       sp_q;

  logic              mat_we, dlt_we, kick_we, sp_we;
  logic [MAT_AW-1:0] mat_waddr, mat_raddr;
  logic [MON_IW-1:0] dlt_waddr;
  logic [CORR_IW-1:0] sp_waddr, cidx;
  logic [31:0]       sp_wdata;
  logic [2*DW-1:0]   dlt_wdata;
  logic [AW-1:0]     kick_wdata;

  // ---------------- load decode ----------------
  logic              in_fire, out_fire;
  logic              row_ok_mat, row_ok_corr, col_ok, mon_ok;
  logic              coef_v;
  logic [CORR_IW-1:0] load_cidx;
  logic [DW-1:0]     dx_w, dy_w;

  assign in_ready = (state_r == ocms_pkg::S_IDLE);
  assign in_fire  = in_valid & in_ready;
  assign out_fire = out_valid_r & out_ready;

  assign coef_v      = (in_command == ocms_pkg::CMD_V_COEF);
  assign row_ok_mat  = {1'b0, in_row_index} < (coef_v ? 7'(V_CORRECTORS) : 7'(H_CORRECTORS));
  assign row_ok_corr = {1'b0, in_row_index} < (in_plane ? 7'(V_CORRECTORS) : 7'(H_CORRECTORS));
  assign col_ok      = {1'b0, in_column_index} < 7'(MONITORS);
  assign mon_ok      = {1'b0, in_row_index} < 7'(MONITORS);
  assign load_cidx   = in_plane ? CORR_IW'(H_CORRECTORS) + CORR_IW'(in_row_index)
                                : CORR_IW'(in_row_index);

  // Form the deltas when the record is loaded; the run only reads them.
  assign dx_w = {in_x_position[31], in_x_position} - {in_x_reference[31], in_x_reference};
  assign dy_w = {in_y_position[31], in_y_position} - {in_y_reference[31], in_y_reference};

  assign mat_we    = in_fire && (in_command == ocms_pkg::CMD_H_COEF || coef_v)
                     && row_ok_mat && col_ok;
  assign mat_waddr = ((coef_v ? MAT_AW'(H_CORRECTORS) : MAT_AW'(0)) + MAT_AW'(in_row_index))
                     * MAT_AW'(MONITORS) + MAT_AW'(in_column_index);
  assign dlt_we    = in_fire && (in_command == ocms_pkg::CMD_MON) && mon_ok;
  assign dlt_waddr = MON_IW'(in_row_index);
  assign dlt_wdata = {dy_w, dx_w};

  // Corrector being worked on in the run
  assign cidx      = plane_r ? CORR_IW'(H_CORRECTORS) + CORR_IW'(row_r) : CORR_IW'(row_r);
  assign mat_raddr = mat_base_r + MAT_AW'(col_r);

  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat_mem[mat_waddr] <= in_coefficient;
    end
    mat_q <= mat_mem[mat_raddr];
  end

  always_ff @(posedge clk) begin
    if (dlt_we) begin
      dlt_mem[dlt_waddr] <= dlt_wdata;
    end
    dlt_q <= dlt_mem[s_r];
  end

  always_ff @(posedge clk) begin
    if (kick_we) begin
      kick_mem[cidx] <= kick_wdata;
    end
    kick_q <= kick_mem[cidx];
  end

  always_ff @(posedge clk) begin
    if (sp_we) begin
      sp_mem[sp_waddr] <= sp_wdata;
    end
    sp_q <= sp_mem[cidx];
  end

  // ---------------- shared slice multiplier ----------------
  localparam int ASL_W_L = ocms_pkg::ASL_W;
  logic                       mul_run, mul_done;
  logic [ASL_W_L-1:0]         a_sl;
  logic [ocms_pkg::BSL_W-1:0] b_sl;
  logic [ocms_pkg::SH_W-1:0]  sh_sel;
  logic [ocms_pkg::PROD_W-1:0] pp_ext;

  assign mul_run  = (state_r == ocms_pkg::S_MAC_MUL) || (state_r == ocms_pkg::S_AP_LMUL)
                    || (state_r == ocms_pkg::S_AP_FMUL);
  assign mul_done = mul_run && (mcnt_r == ocms_pkg::MUL_LAST);
  assign pp_ext   = ocms_pkg::PROD_W'(pp_r);

  always_comb begin
    case (mcnt_r)
      3'd0: begin
        a_sl = opa_r[16:0];  b_sl = opb_r[31:0];  sh_sel = 7'd0;
      end
      3'd1: begin
        a_sl = opa_r[33:17]; b_sl = opb_r[31:0];  sh_sel = 7'd17;
      end
      3'd2: begin
        a_sl = opa_r[50:34]; b_sl = opb_r[31:0];  sh_sel = 7'd34;
      end
      3'd3: begin
        a_sl = opa_r[16:0];  b_sl = opb_r[63:32]; sh_sel = 7'd32;
      end
      3'd4: begin
        a_sl = opa_r[33:17]; b_sl = opb_r[63:32]; sh_sel = 7'd49;
      end
      3'd5: begin
        a_sl = opa_r[50:34]; b_sl = opb_r[63:32]; sh_sel = 7'd66;
      end
      default: begin
        a_sl = '0; b_sl = '0; sh_sel = '0;
      end
    endcase
  end

  // ---------------- run arithmetic ----------------
  logic [ROW_W-1:0]   rows_last;
  logic               s_last, row_last, limited;
  logic [MW-1:0]      lim;
  logic [ocms_pkg::FRAC_W-1:0] frac;
  logic [DW-1:0]      d_cur;
  logic [DW-1:0]      d_mag;
  logic [31:0]        c_mag;
  logic [AW-1:0]      term;
  logic signed [AW-1:0] kick;
  logic [AW-1:0]      acc_mag, kq_mag;
  logic [MW:0]        rem_sh;
  logic               q_bit;
  logic [32:0]        add_mag;
  logic signed [ocms_pkg::SUM_W-1:0] sum, add_s;
  logic signed [31:0] sat;
  logic               cen;

  assign rows_last = plane_r ? ROW_W'(V_CORRECTORS - 1) : ROW_W'(H_CORRECTORS - 1);
  assign row_last  = (row_r == rows_last);
  assign s_last    = (s_r == MON_IW'(MONITORS - 1));
  assign lim       = {(plane_r ? max_v_r : max_h_r), 16'b0};
  assign frac      = plane_r ? frac_v_r : frac_h_r;
  assign limited   = (maxmag_r > lim);

  assign d_cur   = plane_r ? dlt_q[2*DW-1:DW] : dlt_q[DW-1:0];
  assign d_mag   = d_cur[DW-1] ? (~d_cur + 1'b1) : d_cur;
  assign c_mag   = mat_q[31] ? (~mat_q + 1'b1) : mat_q;
  assign term    = prod_r[AW+23:24];
  assign kick    = -acc_r;
  assign acc_mag = acc_r[AW-1] ? AW'(-acc_r) : AW'(acc_r);
  assign kq_mag  = kick_q[AW-1] ? (~kick_q + 1'b1) : kick_q;

  // Restoring divider step: remainder stays below the largest magnitude.
  assign rem_sh = {rem_r[MW-1:0], prod_r[ocms_pkg::PROD_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, maxmag_r});

  // Truncated applied kick, then saturating add to the setpoint
  assign add_mag = prod_r[64:32];
  assign add_s   = neg_r ? -ocms_pkg::SUM_W'({2'b0, add_mag})
                         : ocms_pkg::SUM_W'({2'b0, add_mag});
  assign sum     = {{3{sp_r[31]}}, sp_r} + add_s;
  assign cen     = corr_en_r[cidx];

  always_comb begin
    if (sum > ocms_pkg::SUM_W'(35'sh07FFF_FFFF)) begin
      sat = 32'sh7FFF_FFFF;
    end else if (sum < -ocms_pkg::SUM_W'(35'sh08000_0000)) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = sum[31:0];
    end
  end

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ocms_pkg::S_IDLE: begin
        if (in_fire && in_command == ocms_pkg::CMD_RUN && loaded_r) begin
          state_nxt = ocms_pkg::S_PLANE;
        end
      end
      ocms_pkg::S_PLANE:   state_nxt = ocms_pkg::S_MAC_RD;
      ocms_pkg::S_MAC_RD:  state_nxt = ocms_pkg::S_MAC_CHK;
      ocms_pkg::S_MAC_CHK: begin
        if (mon_en_r[s_r]) begin
          state_nxt = ocms_pkg::S_MAC_MUL;
        end else begin
          state_nxt = s_last ? ocms_pkg::S_ROW_END : ocms_pkg::S_MAC_RD;
        end
      end
      ocms_pkg::S_MAC_MUL: begin
        if (mul_done) begin
          state_nxt = ocms_pkg::S_MAC_ACC;
        end
      end
      ocms_pkg::S_MAC_ACC: state_nxt = s_last ? ocms_pkg::S_ROW_END : ocms_pkg::S_MAC_RD;
      ocms_pkg::S_ROW_END: state_nxt = row_last ? ocms_pkg::S_AP_RD : ocms_pkg::S_MAC_RD;
      ocms_pkg::S_AP_RD:   state_nxt = ocms_pkg::S_AP_CHK;
      ocms_pkg::S_AP_CHK:  state_nxt = limited ? ocms_pkg::S_AP_LMUL : ocms_pkg::S_AP_FMUL;
      ocms_pkg::S_AP_LMUL: begin
        if (mul_done) begin
          state_nxt = ocms_pkg::S_AP_DIV;
        end
      end
      ocms_pkg::S_AP_DIV: begin
        if (dcnt_r == ocms_pkg::DIV_LAST) begin
          state_nxt = ocms_pkg::S_AP_FMUL;
        end
      end
      ocms_pkg::S_AP_FMUL: begin
        if (mul_done) begin
          state_nxt = ocms_pkg::S_AP_ADD;
        end
      end
      ocms_pkg::S_AP_ADD:  state_nxt = ocms_pkg::S_AP_OUT;
      ocms_pkg::S_AP_OUT: begin
        if (out_fire) begin
          if (!row_last) begin
            state_nxt = ocms_pkg::S_AP_RD;
          end else if (plane_r) begin
            state_nxt = ocms_pkg::S_IDLE;
          end else begin
            state_nxt = ocms_pkg::S_PLANE;
          end
        end
      end
      default: state_nxt = ocms_pkg::S_IDLE;
    endcase
  end

  // ---------------- datapath and outputs ----------------
  always_comb begin
    plane_nxt     = plane_r;
    row_nxt       = row_r;
    s_nxt         = s_r;
    col_nxt       = col_r;
    mat_base_nxt  = mat_base_r;
    acc_nxt       = acc_r;
    maxmag_nxt    = maxmag_r;
    opa_nxt       = opa_r;
    opb_nxt       = opb_r;
    neg_nxt       = neg_r;
    mcnt_nxt      = mcnt_r;
    pp_nxt        = pp_r;
    pp_v_nxt      = 1'b0;
    sh_nxt        = sh_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    dcnt_nxt      = dcnt_r;
    sp_nxt        = sp_r;
    out_valid_nxt = out_valid_r;
    out_plane_nxt = out_plane_r;
    out_corr_nxt  = out_corr_r;
    out_sp_nxt    = out_sp_r;
    out_last_nxt  = out_last_r;
    kick_we       = 1'b0;
    kick_wdata    = kick;
    sp_we         = 1'b0;
    sp_waddr      = load_cidx;
    sp_wdata      = in_corrector_setpoint;

    // Multiplier: form one partial product, add the previous one.
    if (mul_run) begin
      pp_nxt   = a_sl * b_sl;
      sh_nxt   = sh_sel;
      pp_v_nxt = (mcnt_r != ocms_pkg::MUL_LAST);
      mcnt_nxt = mcnt_r + 1'b1;
      if (pp_v_r) begin
        prod_nxt = prod_r + (pp_ext << sh_r);
      end
    end

    case (state_r)
      ocms_pkg::S_IDLE: begin
        if (in_fire && in_command == ocms_pkg::CMD_CORR && row_ok_corr) begin
          sp_we = 1'b1;
        end
        plane_nxt = 1'b0;
      end
      ocms_pkg::S_PLANE: begin
        maxmag_nxt   = '0;
        row_nxt      = '0;
        acc_nxt      = '0;
        s_nxt        = '0;
        col_nxt      = '0;
        mat_base_nxt = plane_r ? MAT_AW'(H_CORRECTORS * MONITORS) : MAT_AW'(0);
      end
      ocms_pkg::S_MAC_CHK: begin
        if (mon_en_r[s_r]) begin
          opa_nxt  = ocms_pkg::OPA_W'(d_mag);
          opb_nxt  = ocms_pkg::OPB_W'(c_mag);
          neg_nxt  = d_cur[DW-1] ^ mat_q[31];
          mcnt_nxt = '0;
          prod_nxt = '0;
        end else if (!s_last) begin
          s_nxt = s_r + 1'b1;
        end
      end
      ocms_pkg::S_MAC_ACC: begin
        acc_nxt = neg_r ? acc_r - $signed(term) : acc_r + $signed(term);
        col_nxt = col_r + 1'b1;
        if (!s_last) begin
          s_nxt = s_r + 1'b1;
        end
      end
      ocms_pkg::S_ROW_END: begin
        // Store the negated sum and track the largest magnitude of the plane.
        kick_we = 1'b1;
        if (MW'(acc_mag) > maxmag_r) begin
          maxmag_nxt = MW'(acc_mag);
        end
        acc_nxt = '0;
        s_nxt   = '0;
        col_nxt = '0;
        if (row_last) begin
          row_nxt = '0;
        end else begin
          row_nxt      = row_r + 1'b1;
          mat_base_nxt = mat_base_r + MAT_AW'(MONITORS);
        end
      end
      ocms_pkg::S_AP_CHK: begin
        neg_nxt  = kick_q[AW-1];
        sp_nxt   = cval_r[cidx] ? $signed(sp_q) : 32'sd0;
        opa_nxt  = ocms_pkg::OPA_W'(kq_mag);
        opb_nxt  = limited ? ocms_pkg::OPB_W'(lim) : ocms_pkg::OPB_W'(frac);
        mcnt_nxt = '0;
        prod_nxt = '0;
      end
      ocms_pkg::S_AP_LMUL: begin
        rem_nxt  = '0;
        quo_nxt  = '0;
        dcnt_nxt = '0;
      end
      ocms_pkg::S_AP_DIV: begin
        rem_nxt  = q_bit ? rem_sh - {1'b0, maxmag_r} : rem_sh;
        quo_nxt  = {quo_r[MW-1:0], q_bit};
        prod_nxt = prod_r << 1;
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == ocms_pkg::DIV_LAST) begin
          opa_nxt  = ocms_pkg::OPA_W'({quo_r[MW-1:0], q_bit});
          opb_nxt  = ocms_pkg::OPB_W'(frac);
          mcnt_nxt = '0;
          prod_nxt = '0;
        end
      end
      ocms_pkg::S_AP_ADD: begin
        sp_waddr      = cidx;
        sp_wdata      = sat;
        sp_we         = cen;
        out_valid_nxt = 1'b1;
        out_plane_nxt = plane_r;
        out_corr_nxt  = row_r;
        out_sp_nxt    = cen ? sat : sp_r;
        out_last_nxt  = plane_r && row_last;
      end
      ocms_pkg::S_AP_OUT: begin
        if (out_fire) begin
          out_valid_nxt = 1'b0;
          if (!row_last) begin
            row_nxt = row_r + 1'b1;
          end else begin
            plane_nxt = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ocms_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      pp_v_r      <= 1'b0;
      mon_en_r    <= '0;
      corr_en_r   <= '0;
      cval_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pp_v_r      <= pp_v_nxt;
      if (dlt_we) begin
        mon_en_r[dlt_waddr] <= in_monitor_enabled;
      end
      if (sp_we && state_r == ocms_pkg::S_IDLE) begin
        corr_en_r[sp_waddr] <= in_corrector_enabled;
      end
      if (sp_we) begin
        cval_r[sp_waddr] <= 1'b1;
      end
    end
  end

  // Payload state
  always_ff @(posedge clk) begin
    plane_r     <= plane_nxt;
    row_r       <= row_nxt;
    s_r         <= s_nxt;
    col_r       <= col_nxt;
    mat_base_r  <= mat_base_nxt;
    acc_r       <= acc_nxt;
    maxmag_r    <= maxmag_nxt;
    opa_r       <= opa_nxt;
    opb_r       <= opb_nxt;
    neg_r       <= neg_nxt;
    mcnt_r      <= mcnt_nxt;
    pp_r        <= pp_nxt;
    sh_r        <= sh_nxt;
    prod_r      <= prod_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    dcnt_r      <= dcnt_nxt;
    sp_r        <= sp_nxt;
    out_plane_r <= out_plane_nxt;
    out_corr_r  <= out_corr_nxt;
    out_sp_r    <= out_sp_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_plane        = out_plane_r;
  assign out_corrector    = out_corr_r;
  assign out_new_setpoint = out_sp_r;
  assign out_last         = out_last_r;

  // ---------------- assertions ----------------
  a_no_load_during_result: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result word is pending");

  a_last_on_vertical: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> out_plane)
    else $error("last flag on a horizontal result");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ocms_pkg::S_AP_DIV) |-> (rem_r < {1'b0, maxmag_r}))
    else $error("divider remainder out of range");

  a_result_after_add: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(state_r) == ocms_pkg::S_AP_ADD))
    else $error("result word raised outside the add step");

endmodule
`default_nettype wire

// ===== sim/ocms_checker.sv =====
// Scoreboard for the orbit correction step: mirrors the stores, predicts setpoint words, compares.
`timescale 1ns / 100ps
module ocms_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [ocms_pkg::CMD_W-1:0]    in_command,
  input  logic [ocms_pkg::IDX_W-1:0]    in_row_index,
  input  logic [ocms_pkg::IDX_W-1:0]    in_column_index,
  input  logic                          in_plane,
  input  logic signed [31:0]            in_coefficient,
  input  logic signed [31:0]            in_x_position,
  input  logic signed [31:0]            in_y_position,
  input  logic signed [31:0]            in_x_reference,
  input  logic signed [31:0]            in_y_reference,
  input  logic                          in_monitor_enabled,
  input  logic signed [31:0]            in_corrector_setpoint,
  input  logic                          in_corrector_enabled,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          out_plane,
  input  logic [ocms_pkg::CORR_W-1:0]   out_corrector,
  input  logic signed [31:0]            out_new_setpoint,
  input  logic                          out_last,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [ocms_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [31:0]                   cfg_data,
  output int                            errors,
  output int                            pending
);

  localparam int NMON = ocms_pkg::MONITORS_DEF;
  localparam int NH   = ocms_pkg::H_CORRECTORS_DEF;
  localparam int NV   = ocms_pkg::V_CORRECTORS_DEF;

  typedef struct packed {
    logic                        plane;
    logic [ocms_pkg::CORR_W-1:0] corr;
    logic signed [31:0]          setpoint;
    logic                        last;
  } setpoint_word_t;

  logic signed [31:0] h_coef [0:NH*NMON-1];
  logic signed [31:0] v_coef [0:NV*NMON-1];
  logic signed [31:0] pos_x [0:NMON-1];
  logic signed [31:0] pos_y [0:NMON-1];
  logic signed [31:0] ref_x [0:NMON-1];
  logic signed [31:0] ref_y [0:NMON-1];
  logic               mon_on [0:NMON-1];
  logic signed [31:0] corr_sp [0:NH+NV-1];
  logic               corr_on [0:NH+NV-1];

  logic [ocms_pkg::STEP_W-1:0] step_h, step_v;
  logic [ocms_pkg::FRAC_W-1:0] frac_h, frac_v;
  logic                        matrices_ok;

  setpoint_word_t expected_setpoints[$];
  int err_cnt = 0;

  initial begin
    errors  = 0;
    pending = 0;
  end

  // Sum the matrix row against enabled monitor deltas, limit, scale, update setpoints.
  task automatic correct_plane(input bit pl);
    int             count, base, rank;
    longint signed  acc, dl, cl, add, nv;
    longint signed  kick [0:31];
    logic [63:0]    md, mc, mg, peak, lim;
    logic [127:0]   wide;
    logic signed [31:0] c;
    setpoint_word_t w;
    count = pl ? NV : NH;
    base  = pl ? NH : 0;
    peak  = 0;
    lim   = 64'(pl ? step_v : step_h) << 16;
    for (int i = 0; i < count; i++) begin
      acc  = 0;
      rank = 0;
      for (int s = 0; s < NMON; s++) begin
        if (mon_on[s]) begin
          dl = pl ? longint'(pos_y[s]) - longint'(ref_y[s])
                  : longint'(pos_x[s]) - longint'(ref_x[s]);
          c  = pl ? v_coef[i*NMON + rank] : h_coef[i*NMON + rank];
          cl = longint'(c);
          md = (dl < 0) ? 64'(-dl) : 64'(dl);
          mc = (cl < 0) ? 64'(-cl) : 64'(cl);
          mg = (md * mc) >> 24;
          acc += ((dl < 0) != (cl < 0)) ? -longint'(mg) : longint'(mg);
          rank++;
        end
      end
      kick[i] = -acc;
      mg = (kick[i] < 0) ? 64'(-kick[i]) : 64'(kick[i]);
      if (mg > peak) peak = mg;
    end
    for (int i = 0; i < count; i++) begin
      mg = (kick[i] < 0) ? 64'(-kick[i]) : 64'(kick[i]);
      if (peak > lim) begin
        wide = 128'(mg) * 128'(lim);
        mg   = 64'(wide / 128'(peak));
      end
      wide = 128'(mg) * 128'(pl ? frac_v : frac_h);
      mg   = 64'(wide >> 32);
      add  = (kick[i] < 0) ? -longint'(mg) : longint'(mg);
      nv   = longint'(corr_sp[base+i]);
      if (corr_on[base+i]) begin
        nv += add;
        if (nv > 64'sd2147483647) nv = 64'sd2147483647;
        if (nv < -64'sd2147483648) nv = -64'sd2147483648;
        corr_sp[base+i] = nv[31:0];
      end
      w.plane    = pl;
      w.corr     = ocms_pkg::CORR_W'(i);
      w.setpoint = nv[31:0];
      w.last     = pl && (i == count - 1);
      expected_setpoints.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    setpoint_word_t e;
    if (!rst_n) begin
      for (int k = 0; k < NH*NMON; k++) h_coef[k] = '0;
      for (int k = 0; k < NV*NMON; k++) v_coef[k] = '0;
      for (int k = 0; k < NMON; k++) begin
        pos_x[k] = '0; pos_y[k] = '0; ref_x[k] = '0; ref_y[k] = '0; mon_on[k] = 1'b0;
      end
      for (int k = 0; k < NH+NV; k++) begin
        corr_sp[k] = '0; corr_on[k] = 1'b0;
      end
      step_h = ocms_pkg::STEP_RST; step_v = ocms_pkg::STEP_RST;
      frac_h = ocms_pkg::FRAC_RST; frac_v = ocms_pkg::FRAC_RST;
      matrices_ok = 1'b0;
      expected_setpoints.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ocms_pkg::CFG_MAX_H:  step_h = cfg_data[ocms_pkg::STEP_W-1:0];
          ocms_pkg::CFG_MAX_V:  step_v = cfg_data[ocms_pkg::STEP_W-1:0];
          ocms_pkg::CFG_FRAC_H: frac_h = cfg_data[ocms_pkg::FRAC_W-1:0];
          ocms_pkg::CFG_FRAC_V: frac_v = cfg_data[ocms_pkg::FRAC_W-1:0];
          ocms_pkg::CFG_LOADED: matrices_ok = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        case (in_command)
          ocms_pkg::CMD_H_COEF: if (in_row_index < NH)
                        h_coef[in_row_index*NMON + in_column_index] = in_coefficient;
          ocms_pkg::CMD_V_COEF: if (in_row_index < NV)
                        v_coef[in_row_index*NMON + in_column_index] = in_coefficient;
          ocms_pkg::CMD_MON: begin
            pos_x[in_row_index]  = in_x_position;
            pos_y[in_row_index]  = in_y_position;
            ref_x[in_row_index]  = in_x_reference;
            ref_y[in_row_index]  = in_y_reference;
            mon_on[in_row_index] = in_monitor_enabled;
          end
          ocms_pkg::CMD_CORR: begin
            if (!in_plane && in_row_index < NH) begin
              corr_sp[in_row_index] = in_corrector_setpoint;
              corr_on[in_row_index] = in_corrector_enabled;
            end else if (in_plane && in_row_index < NV) begin
              corr_sp[NH + in_row_index] = in_corrector_setpoint;
              corr_on[NH + in_row_index] = in_corrector_enabled;
            end
          end
          ocms_pkg::CMD_RUN: if (matrices_ok) begin
            correct_plane(1'b0);
            correct_plane(1'b1);
          end
          default: ;  // unknown commands are dropped
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_setpoints.size() == 0) begin
          $error("unexpected setpoint word: plane %0d corrector %0d", out_plane, out_corrector);
          err_cnt++;
        end else begin
          e = expected_setpoints.pop_front();
          if (out_plane !== e.plane) begin
            $error("out_plane: expected %0d, actual %0d", e.plane, out_plane);
            err_cnt++;
          end
          if (out_corrector !== e.corr) begin
            $error("out_corrector: expected %0d, actual %0d", e.corr, out_corrector);
            err_cnt++;
          end
          if (out_new_setpoint !== e.setpoint) begin
            $error("out_new_setpoint: expected %0d, actual %0d", e.setpoint, out_new_setpoint);
            err_cnt++;
          end
          if (out_last !== e.last) begin
            $error("out_last: expected %0d, actual %0d", e.last, out_last);
            err_cnt++;
          end
        end
      end
    end
    errors  <= err_cnt;
    pending <= expected_setpoints.size();
  end

endmodule

// ===== sim/orbit_correction_matrix_step_tb.sv =====
// Top testbench for the orbit correction step: stimulus, register phases and verdict.
`timescale 1ns / 100ps
module orbit_correction_matrix_step_tb;

  localparam int NMON    = ocms_pkg::MONITORS_DEF;
  localparam int NH      = ocms_pkg::H_CORRECTORS_DEF;
  localparam int NV      = ocms_pkg::V_CORRECTORS_DEF;
  localparam int MAX_ON  = 4;     // cap on enabled monitors keeps runs short
  localparam int IDLE_PCT = 27;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [ocms_pkg::CMD_W-1:0]   in_command = ocms_pkg::CMD_H_COEF;
  logic [ocms_pkg::IDX_W-1:0]   in_row_index = '0;
  logic [ocms_pkg::IDX_W-1:0]   in_column_index = '0;
  logic                         in_plane = 1'b0;
  logic signed [31:0]           in_coefficient = '0;
  logic signed [31:0]           in_x_position = '0;
  logic signed [31:0]           in_y_position = '0;
  logic signed [31:0]           in_x_reference = '0;
  logic signed [31:0]           in_y_reference = '0;
  logic                         in_monitor_enabled = 1'b0;
  logic signed [31:0]           in_corrector_setpoint = '0;
  logic                         in_corrector_enabled = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic                         out_plane;
  logic [ocms_pkg::CORR_W-1:0]  out_corrector;
  logic signed [31:0]           out_new_setpoint;
  logic                         out_last;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [ocms_pkg::CFG_IW-1:0]  cfg_index = ocms_pkg::CFG_MAX_H;
  logic [31:0]                  cfg_data = '0;

  int errors;
  int pending;

  // Quiet stretch: no idling on either side.
  bit quiet = 1'b0;

  // Track what has been written so a run never reads an unwritten entry.
  bit h_written [0:NH-1][0:NMON-1];
  bit v_written [0:NV-1][0:NMON-1];
  bit mon_live  [0:NMON-1];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  orbit_correction_matrix_step u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_row_index(in_row_index),
    .in_column_index(in_column_index), .in_plane(in_plane),
    .in_coefficient(in_coefficient),
    .in_x_position(in_x_position), .in_y_position(in_y_position),
    .in_x_reference(in_x_reference), .in_y_reference(in_y_reference),
    .in_monitor_enabled(in_monitor_enabled),
    .in_corrector_setpoint(in_corrector_setpoint),
    .in_corrector_enabled(in_corrector_enabled),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_plane(out_plane), .out_corrector(out_corrector),
    .out_new_setpoint(out_new_setpoint), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ocms_checker u_check (.*);

  // Stall the result side at random, except in the quiet stretch.
  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
  end

  // Mix of full-range, small and extreme 32-bit values.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($urandom_range(2**20)) - 32'(2**19);
      2: return ($urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000);
      default: return 32'($urandom_range(4095)) - 32'd2048;
    endcase
  endfunction

  function automatic int live_count();
    int n;
    n = 0;
    for (int s = 0; s < NMON; s++) n += mon_live[s];
    return n;
  endfunction

  // Drive one input word and hold it until accepted; idle at random first.
  task automatic send_word(input logic [ocms_pkg::CMD_W-1:0] cmd, input int row,
                           input int col, input bit pl, input logic [31:0] coef,
                           input logic [31:0] xp, input logic [31:0] yp,
                           input logic [31:0] xr, input logic [31:0] yr,
                           input bit mon_en, input logic [31:0] sp, input bit corr_en);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid              <= 1'b1;
    in_command            <= cmd;
    in_row_index          <= ocms_pkg::IDX_W'(row);
    in_column_index       <= ocms_pkg::IDX_W'(col);
    in_plane              <= pl;
    in_coefficient        <= coef;
    in_x_position         <= xp;
    in_y_position         <= yp;
    in_x_reference        <= xr;
    in_y_reference        <= yr;
    in_monitor_enabled    <= mon_en;
    in_corrector_setpoint <= sp;
    in_corrector_enabled  <= corr_en;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // mirror the stores the block will hold
    if (cmd == ocms_pkg::CMD_H_COEF && row < NH) h_written[row][col] = 1'b1;
    if (cmd == ocms_pkg::CMD_V_COEF && row < NV) v_written[row][col] = 1'b1;
    if (cmd == ocms_pkg::CMD_MON) mon_live[row] = mon_en;
  endtask

  task automatic send_coef(input logic [ocms_pkg::CMD_W-1:0] cmd, input int row,
                           input int col, input logic [31:0] coef);
    send_word(cmd, row, col, $urandom_range(1), coef, $urandom(), $urandom(), $urandom(),
              $urandom(), $urandom_range(1), $urandom(), $urandom_range(1));
  endtask

  task automatic send_monitor(input int slot, input logic [31:0] xp, input logic [31:0] yp,
                              input logic [31:0] xr, input logic [31:0] yr, input bit en);
    send_word(ocms_pkg::CMD_MON, slot, $urandom_range(63), $urandom_range(1), $urandom(),
              xp, yp, xr, yr, en, $urandom(), $urandom_range(1));
  endtask

  task automatic send_corrector(input int row, input bit pl, input logic [31:0] sp,
                                input bit en);
    send_word(ocms_pkg::CMD_CORR, row, $urandom_range(63), pl, $urandom(), $urandom(),
              $urandom(), $urandom(), $urandom(), $urandom_range(1), sp, en);
  endtask

  task automatic send_other(input logic [ocms_pkg::CMD_W-1:0] cmd);
    send_word(cmd, $urandom_range(63), $urandom_range(63), $urandom_range(1), $urandom(),
              $urandom(), $urandom(), $urandom(), $urandom(), $urandom_range(1),
              $urandom(), $urandom_range(1));
  endtask

  // Write every matrix entry the next run will read, then start the run.
  task automatic start_run();
    int n;
    n = live_count();
    for (int r = 0; r < NH; r++)
      for (int c = 0; c < n; c++)
        if (!h_written[r][c]) send_coef(ocms_pkg::CMD_H_COEF, r, c, pick_word());
    for (int r = 0; r < NV; r++)
      for (int c = 0; c < n; c++)
        if (!v_written[r][c]) send_coef(ocms_pkg::CMD_V_COEF, r, c, pick_word());
    send_other(ocms_pkg::CMD_RUN);
  endtask

  // Drop valid and wait for the block to drain before touching registers.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 || !in_ready) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ocms_pkg::CFG_IW-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(input logic [31:0] sh, input logic [31:0] sv,
                           input logic [31:0] fh, input logic [31:0] fv, input bit ld);
    write_reg(ocms_pkg::CFG_MAX_H, sh);
    write_reg(ocms_pkg::CFG_MAX_V, sv);
    write_reg(ocms_pkg::CFG_FRAC_H, fh);
    write_reg(ocms_pkg::CFG_FRAC_V, fv);
    write_reg(ocms_pkg::CFG_LOADED, 32'(ld));
  endtask

  // One random item; mostly loads that build up a runnable setup, some runs and noise.
  task automatic random_item();
    int  roll, slot;
    bit  en;
    roll = $urandom_range(99);
    if (roll < 40) begin
      send_coef($urandom_range(1) ? ocms_pkg::CMD_V_COEF : ocms_pkg::CMD_H_COEF,
                $urandom_range(99) < 85 ? $urandom_range(23) : $urandom_range(63),
                $urandom_range(99) < 70 ? $urandom_range(MAX_ON-1) : $urandom_range(63),
                pick_word());
    end else if (roll < 58) begin
      slot = $urandom_range(63);
      en   = $urandom_range(1);
      if (en && !mon_live[slot] && live_count() >= MAX_ON) en = 1'b0;
      send_monitor(slot, pick_word(), pick_word(), pick_word(), pick_word(), en);
    end else if (roll < 78) begin
      send_corrector($urandom_range(99) < 85 ? $urandom_range(23) : $urandom_range(63),
                     $urandom_range(1), pick_word(), $urandom_range(99) < 75);
    end else if (roll < 93) begin
      start_run();
    end else begin
      send_other(ocms_pkg::CMD_W'($urandom_range(7, 5)));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: run before the matrices are marked loaded gives nothing.
    send_other(ocms_pkg::CMD_RUN);
    send_other(3'd5);
    send_other(3'd6);
    send_other(3'd7);
    // Monitor extremes, a disabled slot, and the top slot.
    send_monitor(0, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
    send_monitor(63, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
    send_monitor(5, $urandom(), $urandom(), $urandom(), $urandom(), 1'b0);
    // Correctors at the setpoint extremes, one disabled, two beyond range.
    send_corrector(0, 1'b0, 32'h7fff_ffff, 1'b1);
    send_corrector(23, 1'b1, 32'h8000_0000, 1'b1);
    send_corrector(5, 1'b0, 32'h0000_1234, 1'b0);
    send_corrector(24, 1'b0, $urandom(), 1'b1);
    send_corrector(63, 1'b1, $urandom(), 1'b1);
    // Coefficients beyond the row range are dropped; two in range carry extreme values.
    send_coef(ocms_pkg::CMD_H_COEF, 24, 63, $urandom());
    send_coef(ocms_pkg::CMD_V_COEF, 63, 0, $urandom());
    send_coef(ocms_pkg::CMD_H_COEF, 0, 63, 32'h8000_0000);
    send_coef(ocms_pkg::CMD_V_COEF, 23, 0, 32'h7fff_ffff);
    drain();

    // Full-range limits: extreme kicks pass mostly unscaled and saturate.
    write_all(32'h7fff_ffff, 32'h7fff_ffff, 32'd65536, 32'd65536, 1'b1);
    start_run();
    drain();
    // Zero step limit and fractions at zero and above one.
    write_all(32'd0, 32'd0, 32'h1_ffff, 32'd0, 1'b1);
    start_run();
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_all(32'd1000, 32'd5, 32'd65536, 32'd32768, 1'b1);
        1: write_all(32'd0, 32'h7fff_ffff, 32'h1_ffff, 32'd1, 1'b1);
        2: write_all($urandom_range(3000), $urandom_range(3000),
                     $urandom_range(131071), $urandom_range(131071), 1'b0);
        3: write_all(32'h7fff_ffff, 32'd1, 32'd0, 32'h1_ffff, 1'b1);
        default: write_all($urandom(), $urandom(), $urandom_range(131071),
                           $urandom_range(131071), 1'b1);
      endcase
      quiet = (phase == 3);
      for (int n = 0; n < 20; n++) random_item();
      quiet = 1'b0;
      // hold the sender until every setpoint word is back
      drain();
    end

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
